FILE: rtl/sap_pkg.sv
// Shared types and constants of the sweep-and-prune broad phase.
// No dependencies; used by the top level.
package sap_pkg;

    localparam int MaxClientsDef = 64;
    localparam int CoordBitsDef  = 32;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_SORT   = 3'd3,
        ACT_QUERY  = 3'd4
    } t_action;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         client_id;
        logic [5:0]         other_id;
        logic [15:0]        owner_handle;
        logic               is_dynamic;
        logic signed [31:0] low_edge;
        logic signed [31:0] high_edge;
    } t_sap_cmd;

    typedef struct packed {
        logic        status;
        logic [5:0]  assigned_id;
        logic        pair_present;
        logic [15:0] handle_first;
        logic        dynamic_first;
        logic [15:0] handle_second;
        logic        dynamic_second;
    } t_sap_rsp;

endpackage

FILE: rtl/sap_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies.
interface sap_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sap_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sap_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: rtl/sweep_and_prune_broadphase_core.sv
// Sweep-and-prune broad phase core: top level.
// Depends on sap_pkg, sap_stream_if and sap_ram.
//
// Usage:
//   i_cmd carries one command per transfer (add, update, remove, sort, query);
//   o_rsp returns exactly one response per command, in order.
//   The core takes one command at a time: i_cmd.ready is high only while the
//   sequencer is idle. The response sits in an output register, so the core
//   goes idle again as soon as it is loaded; a receiver stall holds that
//   register and blocks only the completion of the following command.
//   Work per command:
//     add     free-slot scan, one slot per cycle
//     update  endpoint list scan, read then write per entry
//     remove  list compaction, then pair-column sweep
//     sort    insertion sort of the endpoint list; each pair change
//             writes row a and then row b of the pair RAM
//     query   handle RAM read twice, pair row once
//   Endpoints share one RAM port pair and one compare unit; pairs and
//   handles have RAMs of their own. Synchronous active-low reset frees
//   every slot, empties the endpoint list and clears all pairs at once
//   (per-row valid bits); no clearing pass is needed.
module sweep_and_prune_broadphase_core #(
    parameter int MAX_CLIENTS = sap_pkg::MaxClientsDef,
    parameter int COORD_BITS  = sap_pkg::CoordBitsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sap_stream_if.sink   i_cmd,
    sap_stream_if.source o_rsp
);
    localparam int NumEp = 2 * MAX_CLIENTS;
    localparam int Cw    = $clog2(MAX_CLIENTS);
    localparam int Ew    = $clog2(NumEp);
    localparam int Nw    = $clog2(NumEp + 1);
    localparam int EpW   = COORD_BITS + Cw + 1;
    localparam logic [8:0]    MaxIds = 9'(MAX_CLIENTS);
    localparam logic [Cw-1:0] LastSlot = Cw'(MAX_CLIENTS - 1);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_ADD_SCN = 21'h000002,
        S_ADD_LO  = 21'h000004,
        S_ADD_HI  = 21'h000008,
        S_UPD_RD  = 21'h000010,
        S_UPD_WR  = 21'h000020,
        S_RM_RD   = 21'h000040,
        S_RM_WR   = 21'h000080,
        S_RM_CRD  = 21'h000100,
        S_RM_CWR  = 21'h000200,
        S_SRT_LD  = 21'h000400,
        S_SRT_T   = 21'h000800,
        S_SRT_CMP = 21'h001000,
        S_SRT_NX  = 21'h002000,
        S_PR_A    = 21'h004000,
        S_PW_A    = 21'h008000,
        S_PR_B    = 21'h010000,
        S_PW_B    = 21'h020000,
        S_Q_H1    = 21'h040000,
        S_Q_H2    = 21'h080000,
        S_FIN     = 21'h100000
    } t_state;

    t_state            r_state, n_state;
    sap_pkg::t_sap_cmd r_cmd, n_cmd;
    sap_pkg::t_sap_rsp r_res, n_res;
    sap_pkg::t_sap_rsp r_od, n_od;
    logic              r_ov, n_ov;
    logic [Nw-1:0]     r_cnt, n_cnt;          // endpoint count
    logic [MAX_CLIENTS-1:0] r_valid, n_valid; // slot in use
    logic [MAX_CLIENTS-1:0] r_dyn, n_dyn;     // slot is dynamic
    logic [MAX_CLIENTS-1:0] r_rowv, n_rowv;   // pair row holds written data
    logic [Cw-1:0]     r_slot, n_slot;        // scan slot / sweep row
    logic [Nw-1:0]     r_a, n_a;              // sort i / read pointer
    logic [Nw-1:0]     r_b, n_b;              // sort k / write pointer
    logic [EpW-1:0]    r_t, n_t;              // endpoint being inserted
    logic [Cw-1:0]     r_pa, n_pa;
    logic [Cw-1:0]     r_pb, n_pb;
    logic              r_pv, n_pv;

    // RAM ports
    logic           ep_we, mx_we, hd_we;
    logic [Ew-1:0]  ep_wa, ep_ra;
    logic [EpW-1:0] ep_wd, ep_q;
    logic [Cw-1:0]  mx_wa, mx_ra, hd_wa, hd_ra;
    logic [MAX_CLIENTS-1:0] mx_wd, mx_q;
    logic [15:0]    hd_wd, hd_q;

    // Edge values truncated or sign-extended to COORD_BITS
    logic [COORD_BITS-1:0] w_lo, w_hi;
    generate
        if (COORD_BITS <= 32) begin : g_narrow
            assign w_lo = r_cmd.low_edge[COORD_BITS-1:0];
            assign w_hi = r_cmd.high_edge[COORD_BITS-1:0];
        end else begin : g_wide
            assign w_lo = {{(COORD_BITS-32){r_cmd.low_edge[31]}}, r_cmd.low_edge};
            assign w_hi = {{(COORD_BITS-32){r_cmd.high_edge[31]}}, r_cmd.high_edge};
        end
    endgenerate

    // Field views of the endpoint entries
    logic [COORD_BITS-1:0] t_key, p_key;
    logic [Cw-1:0]         t_own, p_own, q_own;
    logic                  t_max, p_max;
    assign t_key = r_t[EpW-1 -: COORD_BITS];
    assign t_own = r_t[Cw:1];
    assign t_max = r_t[0];
    assign p_key = ep_q[EpW-1 -: COORD_BITS];
    assign p_own = ep_q[Cw:1];
    assign p_max = ep_q[0];
    assign q_own = p_own;

    logic          w_in_ok, w_q_ok, w_less;
    logic [Cw-1:0] w_in_slot, w_cid, w_oid;
    logic [Nw-1:0] w_km1;
    assign w_in_ok   = ({3'b000, i_cmd.data.client_id} < MaxIds);
    assign w_in_slot = Cw'(i_cmd.data.client_id);
    assign w_cid     = Cw'(r_cmd.client_id);
    assign w_oid     = Cw'(r_cmd.other_id);
    assign w_q_ok    = ({3'b000, r_cmd.client_id} < MaxIds) &&
                       ({3'b000, r_cmd.other_id} < MaxIds);
    assign w_less    = $signed(t_key) < $signed(p_key);
    assign w_km1     = r_b - Nw'(1);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_od;

    always_comb begin
        logic [MAX_CLIENTS-1:0] v_row;
        n_state = r_state;
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_od    = r_od;
        n_ov    = r_ov;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_dyn   = r_dyn;
        n_rowv  = r_rowv;
        n_slot  = r_slot;
        n_a     = r_a;
        n_b     = r_b;
        n_t     = r_t;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_pv    = r_pv;
        ep_we = 1'b0; ep_wa = '0; ep_wd = '0; ep_ra = '0;
        mx_we = 1'b0; mx_wa = '0; mx_wd = '0; mx_ra = '0;
        hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
        v_row = '0;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.data;
                    n_res = '0;
                    n_a   = '0;
                    n_b   = '0;
                    case (i_cmd.data.action)
                        sap_pkg::ACT_ADD: begin
                            n_slot  = '0;
                            n_state = S_ADD_SCN;
                        end
                        sap_pkg::ACT_UPDATE: begin
                            n_state = (w_in_ok && r_valid[w_in_slot]) ? S_UPD_RD : S_FIN;
                        end
                        sap_pkg::ACT_REMOVE: begin
                            n_state = (w_in_ok && r_valid[w_in_slot]) ? S_RM_RD : S_FIN;
                        end
                        sap_pkg::ACT_SORT: begin
                            n_a     = Nw'(1);
                            n_state = S_SRT_LD;
                        end
                        sap_pkg::ACT_QUERY: begin
                            n_state = S_Q_H1;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // Lowest free slot, one per cycle
            S_ADD_SCN: begin
                if (!r_valid[r_slot]) begin
                    n_state = S_ADD_LO;
                end else if (r_slot == LastSlot) begin
                    n_res.status = sap_pkg::STATUS_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_slot = r_slot + Cw'(1);
                end
            end
            S_ADD_LO: begin
                ep_we = 1'b1;
                ep_wa = r_cnt[Ew-1:0];
                ep_wd = {w_lo, r_slot, 1'b0};
                hd_we = 1'b1;
                hd_wa = r_slot;
                hd_wd = r_cmd.owner_handle;
                n_valid[r_slot] = 1'b1;
                n_dyn[r_slot]   = r_cmd.is_dynamic;
                n_state = S_ADD_HI;
            end
            S_ADD_HI: begin
                ep_we = 1'b1;
                ep_wa = Ew'(r_cnt + Nw'(1));
                ep_wd = {w_hi, r_slot, 1'b1};
                n_cnt = r_cnt + Nw'(2);
                n_res.assigned_id = 6'(r_slot);
                n_state = S_FIN;
            end

            // Update: rewrite both endpoints owned by the client
            S_UPD_RD: begin
                if (r_a >= r_cnt) begin
                    n_state = S_FIN;
                end else begin
                    ep_ra   = r_a[Ew-1:0];
                    n_state = S_UPD_WR;
                end
            end
            S_UPD_WR: begin
                if (q_own == w_cid) begin
                    ep_we = 1'b1;
                    ep_wa = r_a[Ew-1:0];
                    ep_wd = {(p_max ? w_hi : w_lo), q_own, p_max};
                end
                n_a     = r_a + Nw'(1);
                n_state = S_UPD_RD;
            end

            // Remove: compact the list, then clear the pair column
            S_RM_RD: begin
                if (r_a >= r_cnt) begin
                    n_cnt   = r_b;
                    n_slot  = '0;
                    n_state = S_RM_CRD;
                end else begin
                    ep_ra   = r_a[Ew-1:0];
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                if (q_own != w_cid) begin
                    ep_we = 1'b1;
                    ep_wa = r_b[Ew-1:0];
                    ep_wd = ep_q;
                    n_b   = r_b + Nw'(1);
                end
                n_a     = r_a + Nw'(1);
                n_state = S_RM_RD;
            end
            S_RM_CRD: begin
                mx_ra   = r_slot;
                n_state = S_RM_CWR;
            end
            S_RM_CWR: begin
                if (r_rowv[r_slot]) begin
                    v_row        = mx_q;
                    v_row[w_cid] = 1'b0;
                    mx_we = 1'b1;
                    mx_wa = r_slot;
                    mx_wd = v_row;
                end
                if (r_slot == LastSlot) begin
                    n_rowv[w_cid]  = 1'b0;
                    n_valid[w_cid] = 1'b0;
                    n_dyn[w_cid]   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_slot  = r_slot + Cw'(1);
                    n_state = S_RM_CRD;
                end
            end

            // Insertion sort: r_a = i, r_b = k, r_t = entry moving left
            S_SRT_LD: begin
                if (r_a >= r_cnt) begin
                    n_state = S_FIN;
                end else begin
                    ep_ra   = r_a[Ew-1:0];
                    n_b     = r_a;
                    n_state = S_SRT_T;
                end
            end
            S_SRT_T: begin
                n_t     = ep_q;
                ep_ra   = w_km1[Ew-1:0];
                n_state = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                if (w_less) begin
                    ep_we = 1'b1;
                    ep_wa = r_b[Ew-1:0];
                    ep_wd = ep_q;
                    n_b   = w_km1;
                    if ((t_max != p_max) && (r_dyn[t_own] || r_dyn[p_own])) begin
                        n_pa    = t_own;
                        n_pb    = p_own;
                        n_pv    = !t_max;
                        n_state = S_PR_A;
                    end else begin
                        n_state = S_SRT_NX;
                    end
                end else begin
                    ep_we   = 1'b1;
                    ep_wa   = r_b[Ew-1:0];
                    ep_wd   = r_t;
                    n_a     = r_a + Nw'(1);
                    n_state = S_SRT_LD;
                end
            end
            S_SRT_NX: begin
                if (r_b == '0) begin
                    ep_we   = 1'b1;
                    ep_wa   = '0;
                    ep_wd   = r_t;
                    n_a     = r_a + Nw'(1);
                    n_state = S_SRT_LD;
                end else begin
                    ep_ra   = w_km1[Ew-1:0];
                    n_state = S_SRT_CMP;
                end
            end

            // Symmetric pair write: row a bit b, then row b bit a
            S_PR_A: begin
                mx_ra   = r_pa;
                n_state = S_PW_A;
            end
            S_PW_A: begin
                v_row       = r_rowv[r_pa] ? mx_q : '0;
                v_row[r_pb] = r_pv;
                mx_we = 1'b1;
                mx_wa = r_pa;
                mx_wd = v_row;
                n_rowv[r_pa] = 1'b1;
                n_state = S_PR_B;
            end
            S_PR_B: begin
                mx_ra   = r_pb;
                n_state = S_PW_B;
            end
            S_PW_B: begin
                v_row       = r_rowv[r_pb] ? mx_q : '0;
                v_row[r_pa] = r_pv;
                mx_we = 1'b1;
                mx_wa = r_pb;
                mx_wd = v_row;
                n_rowv[r_pb] = 1'b1;
                n_state = S_SRT_NX;
            end

            // Query: handle RAM read twice, pair row once
            S_Q_H1: begin
                if (w_q_ok) begin
                    hd_ra   = w_cid;
                    mx_ra   = w_cid;
                    n_state = S_Q_H2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_Q_H2: begin
                n_res.handle_first  = r_valid[w_cid] ? hd_q : 16'h0000;
                n_res.dynamic_first = r_valid[w_cid] && r_dyn[w_cid];
                n_res.pair_present  = r_rowv[w_cid] && mx_q[w_oid];
                n_res.dynamic_second = r_valid[w_oid] && r_dyn[w_oid];
                hd_ra   = w_oid;
                n_state = S_FIN;
                // second handle lands next cycle; FIN picks it up below
            end

            S_FIN: begin
                // keep the second handle on the read port while the output waits
                hd_ra = w_oid;
                if (!r_ov || o_rsp.ready) begin
                    n_od    = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd.action == sap_pkg::ACT_QUERY && w_q_ok) begin
                        n_od.handle_second = r_valid[w_oid] ? hd_q : 16'h0000;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_valid <= '0;
            r_dyn   <= '0;
            r_rowv  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            r_dyn   <= n_dyn;
            r_rowv  <= n_rowv;
        end
        r_cmd  <= n_cmd;
        r_res  <= n_res;
        r_od   <= n_od;
        r_slot <= n_slot;
        r_a    <= n_a;
        r_b    <= n_b;
        r_t    <= n_t;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_pv   <= n_pv;
    end

    sap_ram #(.Width(EpW), .Depth(NumEp)) u_ep_ram (
        .i_clk   (i_clk),
        .i_we    (ep_we),
        .i_waddr (ep_wa),
        .i_wdata (ep_wd),
        .i_raddr (ep_ra),
        .o_rdata (ep_q)
    );

    sap_ram #(.Width(MAX_CLIENTS), .Depth(MAX_CLIENTS)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (mx_we),
        .i_waddr (mx_wa),
        .i_wdata (mx_wd),
        .i_raddr (mx_ra),
        .o_rdata (mx_q)
    );

    sap_ram #(.Width(16), .Depth(MAX_CLIENTS)) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (hd_wa),
        .i_wdata (hd_wd),
        .i_raddr (hd_ra),
        .o_rdata (hd_q)
    );

    // Two endpoints per client, never more than the list holds
    a_cnt_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cnt[0] && (r_cnt <= Nw'(NumEp)))
        else $error("endpoint count odd or over capacity");

    // Count tracks the number of live slots
    a_cnt_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == Nw'(2 * $countones(r_valid))))
        else $error("endpoint count out of step with slot table");

    // An accepted command always leaves idle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != S_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // The inner sort step always has a left neighbor to compare with
    a_sort_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRT_T) |-> (r_b != '0))
        else $error("sort compare at position zero");
endmodule
